// ----- src/rigid_body_verlet_integrator_assert.svh -----
// assertion macros for the rigid body integrator checker
// no dependencies
`ifndef RIGID_BODY_VERLET_INTEGRATOR_ASSERT_SVH
`define RIGID_BODY_VERLET_INTEGRATOR_ASSERT_SVH

// checked only outside reset
`define RBVI_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked during reset as well
`define RBVI_CHECK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/rbvi_pkg.sv -----
// shared types, codes and fixed-point helpers for the rigid body integrator
// no dependencies
package rbvi_pkg;

  localparam int FRAC_BITS = 16;
  localparam int MIN_SPEED_SQ = 0;

  typedef logic signed [31:0] q_t;
  typedef logic signed [66:0] wide_t;

  typedef struct packed {
    q_t                 a;
    logic signed [32:0] b;
  } mul_req_t;

  localparam logic [3:0] FN_FORCE      = 4'd0;
  localparam logic [3:0] FN_TORQUE     = 4'd1;
  localparam logic [3:0] FN_FORCE_AT   = 4'd2;
  localparam logic [3:0] FN_IMPULSE    = 4'd3;
  localparam logic [3:0] FN_ANG_IMP    = 4'd4;
  localparam logic [3:0] FN_IMPULSE_AT = 4'd5;
  localparam logic [3:0] FN_SET_VEL    = 4'd6;
  localparam logic [3:0] FN_SET_SPIN   = 4'd7;
  localparam logic [3:0] FN_STEP       = 4'd8;
  localparam logic [3:0] FN_SET_POSE   = 4'd9;

  localparam logic [3:0] REG_TIME_STEP = 4'd0;
  localparam logic [3:0] REG_INV_MASS  = 4'd1;
  localparam logic [3:0] REG_INV_INERT = 4'd2;
  localparam logic [3:0] REG_WEIGHT    = 4'd3;
  localparam logic [3:0] REG_LIM_X     = 4'd4;
  localparam logic [3:0] REG_LIM_Y     = 4'd5;
  localparam logic [3:0] REG_LIM_ANG   = 4'd6;
  localparam logic [3:0] REG_FREEZE    = 4'd7;

  localparam logic [4:0] OP_VERLET_FIRST = 5'd0;
  localparam logic [4:0] OP_VERLET_LAST  = 5'd11;
  localparam logic [4:0] OP_SQ0          = 5'd12;
  localparam logic [4:0] OP_SQ1          = 5'd13;
  localparam logic [4:0] OP_ADV          = 5'd16;
  localparam logic [4:0] OP_ADV_LAST     = 5'd26;
  localparam logic [4:0] OP_ADV_END      = 5'd27;
  localparam logic [4:0] OP_LEV0         = 5'd28;
  localparam logic [4:0] OP_LEV1         = 5'd29;

  function automatic q_t sat32(input wide_t v);
    if (v > 67'sd2147483647) return 32'sh7fffffff;
    else if (v < -67'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

  function automatic q_t qshift(input wide_t v);
    wide_t s;
    s = v >>> FRAC_BITS;
    return sat32(s);
  endfunction

  function automatic q_t qadd(input q_t a, input q_t b);
    return sat32(67'(a) + 67'(b));
  endfunction

  function automatic q_t clamp_lim(input q_t v, input logic [63:0] lim);
    q_t lo;
    q_t hi;
    q_t r;
    lo = lim[31:0];
    hi = lim[63:32];
    r = v;
    if (r < lo) r = lo;
    if (r > hi) r = hi;
    return r;
  endfunction

endpackage

// ----- src/rbvi_mul.sv -----
// shared signed multiplier with registered full-width product
// depends on rbvi_pkg
module rbvi_mul (
  input  logic                clk,
  input  rbvi_pkg::mul_req_t  req,
  output logic signed [64:0]  prod
);

  always_ff @(posedge clk) begin
    prod <= 65'(req.a) * 65'(req.b);
  end

endmodule

// ----- src/rigid_body_verlet_integrator.sv -----
// 2d rigid body integrator top level: sequencer, body state and stream ports
// depends on rbvi_pkg and rbvi_mul
//
// one input beat on s_* carries an event: tuser holds func, tdata the vectors
// every event returns one beat on m_* with the pose and velocities after it
// configuration registers are written over cfg_valid/cfg_ready, index and data;
// the user must write them only while no event is in flight, which the block
// does not enforce; index values beyond the list are ignored
// s_tready is high only while the block is idle: one event at a time
// accumulate, set, unused events go idle to done; a force or impulse at a point
// takes two multiplier passes; a step issues 23 operations to the one shared
// multiplier, folded back into the state by saturating add, clamp or compare
// a result waiting on m_tready blocks the finish of the following event only;
// the next input beat is still accepted as soon as the block is idle
// rst is synchronous: state clears to zero, registers to their reset values,
// and m_tvalid drops
module rigid_body_verlet_integrator (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [159:0] s_tdata,   // vec_x, vec_y, scalar_value, point_x, point_y
  input  logic [3:0]   s_tuser,   // func
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [191:0] m_tdata,   // position_x, position_y, orientation_out,
                                  // velocity_x, velocity_y, spin_out
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [3:0]   cfg_index,
  input  logic [63:0]  cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ISSUE = 4'b0010,
    ST_TAKE  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t state;
  logic [4:0] op;

  logic [30:0] time_step, inverse_mass, inverse_inertia;
  logic [63:0] weight_force, lim_x, lim_y, lim_ang;
  logic [2:0]  freeze;

  rbvi_pkg::q_t vel [3];
  rbvi_pkg::q_t accv[3];
  rbvi_pkg::q_t frc [3];
  rbvi_pkg::q_t imp [3];
  rbvi_pkg::q_t pos [3];

  rbvi_pkg::q_t tmp1, tmp2, lev_rx, lev_ry, lev_vx, lev_vy;
  logic lev_imp;
  logic moving;
  logic signed [64:0] pf;

  rbvi_pkg::mul_req_t req;
  logic signed [64:0] prod;

  rbvi_pkg::q_t vin[3];
  rbvi_pkg::q_t pin_x, pin_y;
  logic [1:0] ax;
  logic [1:0] sub;
  logic signed [32:0] h33, dt33, inv33;
  logic [63:0] lim_sel;
  rbvi_pkg::q_t q, lev_t, step_v;
  logic sq_big;

  rbvi_mul u_mul (
    .clk  (clk),
    .req  (req),
    .prod (prod)
  );

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  assign vin[0] = s_tdata[31:0];
  assign vin[1] = s_tdata[63:32];
  assign vin[2] = s_tdata[95:64];
  assign pin_x  = s_tdata[127:96];
  assign pin_y  = s_tdata[159:128];

  assign ax    = op[3:2];
  assign sub   = op[1:0];
  assign h33   = {3'b000, time_step[30:1]};
  assign dt33  = {2'b00, time_step};
  assign inv33 = (ax == 2'd2) ? {2'b00, inverse_inertia} : {2'b00, inverse_mass};

  always_comb begin
    case (ax)
      2'd0:    lim_sel = lim_x;
      2'd1:    lim_sel = lim_y;
      default: lim_sel = lim_ang;
    endcase
  end

  always_comb begin
    req.a = '0;
    req.b = '0;
    case (op) inside
      [rbvi_pkg::OP_VERLET_FIRST:rbvi_pkg::OP_VERLET_LAST]: begin
        case (sub)
          2'd0:    begin req.a = accv[ax]; req.b = h33;   end
          2'd1:    begin req.a = frc[ax];  req.b = inv33; end
          2'd2:    begin req.a = accv[ax]; req.b = h33;   end
          default: begin req.a = imp[ax];  req.b = inv33; end
        endcase
      end
      rbvi_pkg::OP_SQ0: begin req.a = vel[0]; req.b = 33'(vel[0]); end
      rbvi_pkg::OP_SQ1: begin req.a = vel[1]; req.b = 33'(vel[1]); end
      [rbvi_pkg::OP_ADV:rbvi_pkg::OP_ADV_END]: begin
        case (sub)
          2'd0:    begin req.a = vel[ax];  req.b = dt33; end
          2'd1:    begin req.a = accv[ax]; req.b = dt33; end
          default: begin req.a = tmp2;     req.b = h33;  end
        endcase
      end
      rbvi_pkg::OP_LEV0: begin req.a = lev_ry; req.b = 33'(lev_vx); end
      rbvi_pkg::OP_LEV1: begin req.a = lev_rx; req.b = 33'(lev_vy); end
      default: begin req.a = '0; req.b = '0; end
    endcase
  end

  assign q      = rbvi_pkg::qshift(67'(prod));
  assign lev_t  = rbvi_pkg::qshift(67'(pf) - 67'(prod));
  assign step_v = rbvi_pkg::qadd(vel[ax], q);
  assign sq_big = ((67'(pf) + 67'(prod)) >>> rbvi_pkg::FRAC_BITS)
                  > 67'(rbvi_pkg::MIN_SPEED_SQ);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      op       <= '0;
      m_tvalid <= 1'b0;
      time_step       <= 31'd1092;
      inverse_mass    <= 31'd65536;
      inverse_inertia <= 31'd65536;
      weight_force    <= '0;
      lim_x           <= '0;
      lim_y           <= '0;
      lim_ang         <= '0;
      freeze          <= '0;
      moving          <= 1'b0;
      lev_imp         <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        vel[i]  <= '0;
        accv[i] <= '0;
        frc[i]  <= '0;
        imp[i]  <= '0;
        pos[i]  <= '0;
      end
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          rbvi_pkg::REG_TIME_STEP: time_step       <= cfg_data[30:0];
          rbvi_pkg::REG_INV_MASS:  inverse_mass    <= cfg_data[30:0];
          rbvi_pkg::REG_INV_INERT: inverse_inertia <= cfg_data[30:0];
          rbvi_pkg::REG_WEIGHT:    weight_force    <= cfg_data;
          rbvi_pkg::REG_LIM_X:     lim_x           <= cfg_data;
          rbvi_pkg::REG_LIM_Y:     lim_y           <= cfg_data;
          rbvi_pkg::REG_LIM_ANG:   lim_ang         <= cfg_data;
          rbvi_pkg::REG_FREEZE: begin
            freeze <= cfg_data[2:0];
            for (int i = 0; i < 2; i++) begin
              if (cfg_data[i]) begin
                vel[i]  <= '0;
                frc[i]  <= '0;
                accv[i] <= '0;
              end
            end
          end
          default: ;
        endcase
      end

      unique case (state)
        ST_IDLE: begin
          if (s_tvalid && s_tready) begin
            state <= ST_DONE;
            case (s_tuser) inside
              rbvi_pkg::FN_FORCE:
                for (int i = 0; i < 2; i++)
                  if (!freeze[i]) frc[i] <= rbvi_pkg::qadd(frc[i], vin[i]);
              rbvi_pkg::FN_TORQUE:
                if (!freeze[2]) frc[2] <= rbvi_pkg::qadd(frc[2], vin[2]);
              rbvi_pkg::FN_IMPULSE:
                for (int i = 0; i < 2; i++)
                  if (!freeze[i]) imp[i] <= rbvi_pkg::qadd(imp[i], vin[i]);
              rbvi_pkg::FN_ANG_IMP:
                if (!freeze[2]) imp[2] <= rbvi_pkg::qadd(imp[2], vin[2]);
              rbvi_pkg::FN_SET_VEL:
                for (int i = 0; i < 2; i++)
                  if (!freeze[i]) vel[i] <= vin[i];
              rbvi_pkg::FN_SET_SPIN:
                if (!freeze[2]) vel[2] <= vin[2];
              rbvi_pkg::FN_SET_POSE:
                for (int i = 0; i < 3; i++) pos[i] <= vin[i];
              rbvi_pkg::FN_STEP: begin
                op    <= rbvi_pkg::OP_VERLET_FIRST;
                state <= ST_ISSUE;
              end
              rbvi_pkg::FN_FORCE_AT, rbvi_pkg::FN_IMPULSE_AT: begin
                lev_rx  <= rbvi_pkg::sat32(67'(pin_x) - 67'(pos[0]));
                lev_ry  <= rbvi_pkg::sat32(67'(pin_y) - 67'(pos[1]));
                lev_vx  <= vin[0];
                lev_vy  <= vin[1];
                lev_imp <= (s_tuser == rbvi_pkg::FN_IMPULSE_AT);
                op      <= rbvi_pkg::OP_LEV0;
                state   <= ST_ISSUE;
              end
              default: ;
            endcase
          end
        end
        ST_ISSUE: state <= ST_TAKE;
        ST_TAKE: begin
          state <= ST_ISSUE;
          op    <= op + 5'd1;
          case (op) inside
            [rbvi_pkg::OP_VERLET_FIRST:rbvi_pkg::OP_VERLET_LAST]: begin
              case (sub) inside
                2'd0, 2'd2: vel[ax] <= step_v;
                2'd1:       accv[ax] <= q;
                default:    vel[ax] <= rbvi_pkg::clamp_lim(step_v, lim_sel);
              endcase
              if (op == rbvi_pkg::OP_VERLET_LAST) begin
                frc[0] <= freeze[1] ? '0 : weight_force[31:0];
                frc[1] <= freeze[1] ? '0 : weight_force[63:32];
                frc[2] <= '0;
                for (int i = 0; i < 3; i++) imp[i] <= '0;
              end
            end
            rbvi_pkg::OP_SQ0: pf <= prod;
            rbvi_pkg::OP_SQ1: begin
              moving <= sq_big;
              op     <= rbvi_pkg::OP_ADV;
            end
            [rbvi_pkg::OP_ADV:rbvi_pkg::OP_ADV_END]: begin
              case (sub)
                2'd0: tmp1 <= q;
                2'd1: tmp2 <= q;
                default: begin
                  if (moving || ax == 2'd2)
                    pos[ax] <= rbvi_pkg::qadd(pos[ax], rbvi_pkg::qadd(tmp1, q));
                  op <= op + 5'd2;
                  if (op == rbvi_pkg::OP_ADV_LAST) state <= ST_DONE;
                end
              endcase
            end
            rbvi_pkg::OP_LEV0: pf <= prod;
            rbvi_pkg::OP_LEV1: begin
              state <= ST_DONE;
              if (lev_imp) begin
                if (!freeze[2]) imp[2] <= rbvi_pkg::qadd(imp[2], lev_t);
                if (!freeze[0]) imp[0] <= rbvi_pkg::qadd(imp[0], lev_vx);
                if (!freeze[1]) imp[1] <= rbvi_pkg::qadd(imp[1], lev_vy);
              end else begin
                if (!freeze[2]) frc[2] <= rbvi_pkg::qadd(frc[2], lev_t);
                if (!freeze[0]) frc[0] <= rbvi_pkg::qadd(frc[0], lev_vx);
                if (!freeze[1]) frc[1] <= rbvi_pkg::qadd(frc[1], lev_vy);
              end
            end
            default: state <= ST_DONE;
          endcase
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {vel[2], vel[1], vel[0], pos[2], pos[1], pos[0]};
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- src/rbvi_checker.sv -----
// port-level checker for the rigid body integrator, bound to the top level
// depends on rigid_body_verlet_integrator_assert.svh
`include "rigid_body_verlet_integrator_assert.svh"

module rbvi_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [191:0] m_tdata
);

  `RBVI_CHECK(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "output beat changed while stalled")
  `RBVI_CHECK(a_one_event, s_tvalid && s_tready |=> !s_tready, "input taken while an event is in flight")
  `RBVI_CHECK_ALWAYS(a_reset_quiet, rst |=> !m_tvalid, "output valid right after reset")

endmodule

bind rigid_body_verlet_integrator rbvi_checker u_rbvi_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ----- dv/rigid_body_verlet_integrator_test.sv -----
// self-checking bench for rigid_body_verlet_integrator: random and directed body events
// depends on rbvi_pkg for codes and the top level rtl; prediction is computed in-bench
module rigid_body_verlet_integrator_test;

  localparam logic [3:0] REG_UNKNOWN = 4'd12;

  typedef struct packed {
    logic [3:0] func;
    logic [31:0] vx, vy, sc, px, py;
  } event_t;

  // lowest field last so that it lands in the low bits
  typedef struct packed {
    logic [31:0] sp, vy, vx, ang, py, px;
  } pose_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [159:0] s_tdata = '0;
  logic [3:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [191:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [3:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  rigid_body_verlet_integrator dut (.*);

  initial forever #1 clk = ~clk;

  // body model
  logic [31:0] r_dt, r_imass, r_iinert;
  logic [63:0] r_weight, r_limx, r_limy, r_lima;
  logic [2:0] r_frz;
  longint b_vx, b_vy, b_sp, b_ax, b_ay, b_aa, b_fx, b_fy, b_tq, b_ix, b_iy, b_ia;
  longint b_px, b_py, b_ang;

  event_t pending_events[$];
  pose_t expected_poses[$];
  int errors = 0, reported = 0, received = 0, cycles = 0;
  bit quiet = 0, hold_off = 0;
  bit in_beat = 0;

  function automatic longint sat(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint s32(logic [31:0] u);
    return longint'(signed'(u));
  endfunction

  function automatic longint fmul(longint a, longint b);
    logic signed [127:0] p;
    p = 128'(a) * 128'(b);
    p = p >>> rbvi_pkg::FRAC_BITS;
    if (p > 128'sd2147483647) return 64'sd2147483647;
    if (p < -128'sd2147483648) return -64'sd2147483648;
    return longint'(p);
  endfunction

  function automatic longint clampv(longint v, logic [63:0] lim);
    if (v < s32(lim[31:0])) v = s32(lim[31:0]);
    if (v > s32(lim[63:32])) v = s32(lim[63:32]);
    return v;
  endfunction

  function automatic void body_reset();
    r_dt = 1092; r_imass = 65536; r_iinert = 65536;
    r_weight = 0; r_limx = 0; r_limy = 0; r_lima = 0; r_frz = 0;
    {b_vx, b_vy, b_sp, b_ax, b_ay, b_aa, b_fx, b_fy, b_tq} = '0;
    {b_ix, b_iy, b_ia, b_px, b_py, b_ang} = '0;
  endfunction

  function automatic void body_config(logic [3:0] idx, logic [63:0] d);
    case (idx)
      rbvi_pkg::REG_TIME_STEP: r_dt = {1'b0, d[30:0]};
      rbvi_pkg::REG_INV_MASS: r_imass = {1'b0, d[30:0]};
      rbvi_pkg::REG_INV_INERT: r_iinert = {1'b0, d[30:0]};
      rbvi_pkg::REG_WEIGHT: r_weight = d;
      rbvi_pkg::REG_LIM_X: r_limx = d;
      rbvi_pkg::REG_LIM_Y: r_limy = d;
      rbvi_pkg::REG_LIM_ANG: r_lima = d;
      rbvi_pkg::REG_FREEZE: begin
        r_frz = d[2:0];
        if (r_frz[0]) begin b_vx = 0; b_fx = 0; b_ax = 0; end
        if (r_frz[1]) begin b_vy = 0; b_fy = 0; b_ay = 0; end
      end
      default: ;
    endcase
  endfunction

  function automatic longint verlet_velocity(longint v, ref longint acc, input longint f,
                                             longint imp, longint inv, longint h,
                                             logic [63:0] lim);
    longint half;
    half = sat(v + fmul(acc, h));
    acc = fmul(f, inv);
    v = sat(half + fmul(acc, h));
    v = sat(v + fmul(imp, inv));
    return clampv(v, lim);
  endfunction

  function automatic longint advance_pose(longint p, longint v, longint a, longint dt,
                                          longint h);
    return sat(p + sat(fmul(v, dt) + fmul(fmul(a, dt), h)));
  endfunction

  function automatic void body_linear(ref longint sx, ref longint sy, input longint x,
                                      longint y);
    if (!r_frz[0]) sx = sat(sx + x);
    if (!r_frz[1]) sy = sat(sy + y);
  endfunction

  function automatic pose_t body_event(event_t e);
    longint vx, vy, sc, px, py, dt, h, t;
    logic [63:0] sq;
    pose_t r;
    vx = s32(e.vx); vy = s32(e.vy); sc = s32(e.sc); px = s32(e.px); py = s32(e.py);
    case (e.func)
      rbvi_pkg::FN_FORCE: body_linear(b_fx, b_fy, vx, vy);
      rbvi_pkg::FN_TORQUE: if (!r_frz[2]) b_tq = sat(b_tq + sc);
      rbvi_pkg::FN_FORCE_AT: begin
        t = fmul(sat(py - b_py) * vx - sat(px - b_px) * vy, 1);
        if (!r_frz[2]) b_tq = sat(b_tq + t);
        body_linear(b_fx, b_fy, vx, vy);
      end
      rbvi_pkg::FN_IMPULSE: body_linear(b_ix, b_iy, vx, vy);
      rbvi_pkg::FN_ANG_IMP: if (!r_frz[2]) b_ia = sat(b_ia + sc);
      rbvi_pkg::FN_IMPULSE_AT: begin
        t = fmul(sat(py - b_py) * vx - sat(px - b_px) * vy, 1);
        if (!r_frz[2]) b_ia = sat(b_ia + t);
        body_linear(b_ix, b_iy, vx, vy);
      end
      rbvi_pkg::FN_SET_VEL: begin
        if (!r_frz[0]) b_vx = vx;
        if (!r_frz[1]) b_vy = vy;
      end
      rbvi_pkg::FN_SET_SPIN: if (!r_frz[2]) b_sp = sc;
      rbvi_pkg::FN_STEP: begin
        dt = r_dt; h = r_dt >> 1;
        b_vx = verlet_velocity(b_vx, b_ax, b_fx, b_ix, r_imass, h, r_limx);
        b_vy = verlet_velocity(b_vy, b_ay, b_fy, b_iy, r_imass, h, r_limy);
        b_sp = verlet_velocity(b_sp, b_aa, b_tq, b_ia, r_iinert, h, r_lima);
        if (r_frz[1]) begin b_fx = 0; b_fy = 0; end
        else begin b_fx = s32(r_weight[31:0]); b_fy = s32(r_weight[63:32]); end
        b_tq = 0; b_ix = 0; b_iy = 0; b_ia = 0;
        sq = (64'(b_vx * b_vx) + 64'(b_vy * b_vy)) >> rbvi_pkg::FRAC_BITS;
        if (sq > 64'(rbvi_pkg::MIN_SPEED_SQ)) begin
          b_px = advance_pose(b_px, b_vx, b_ax, dt, h);
          b_py = advance_pose(b_py, b_vy, b_ay, dt, h);
        end
        b_ang = advance_pose(b_ang, b_sp, b_aa, dt, h);
      end
      rbvi_pkg::FN_SET_POSE: begin b_px = vx; b_py = vy; b_ang = sc; end
      default: ;
    endcase
    r.px = b_px[31:0]; r.py = b_py[31:0]; r.ang = b_ang[31:0];
    r.vx = b_vx[31:0]; r.vy = b_vy[31:0]; r.sp = b_sp[31:0];
    return r;
  endfunction

  // input beats are taken at the rising edge
  always @(posedge clk) begin
    in_beat = !rst && s_tvalid && s_tready;
    if (in_beat) expected_poses.push_back(body_event(pending_events.pop_front()));
  end

  // sender: one event per beat, random bursts of gaps, a waiting beat is held
  int send_gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (send_gap > 0) send_gap = send_gap - 1;
      else if (!quiet && $urandom_range(0, 15) == 0) send_gap = $urandom_range(1, 18);
      if (pending_events.size() > 0 && (send_gap == 0 || (s_tvalid && !in_beat))) begin
        s_tvalid <= 1'b1;
        s_tuser <= pending_events[0].func;
        s_tdata <= {pending_events[0].py, pending_events[0].px, pending_events[0].sc,
                    pending_events[0].vy, pending_events[0].vx};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off
  int recv_gap = 0;
  always @(negedge clk) begin
    if (recv_gap > 0) recv_gap = recv_gap - 1;
    else if (!quiet && $urandom_range(0, 15) == 0) recv_gap = $urandom_range(1, 18);
    m_tready <= !rst && !hold_off && recv_gap == 0;
  end

  always @(posedge clk) begin
    pose_t got, want;
    cycles <= cycles + 1;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      received <= received + 1;
      if (expected_poses.size() == 0) begin
        errors = errors + 1;
        if (reported < 10) $display("result beat with nothing pending: %h", got);
        reported = reported + 1;
      end else begin
        want = expected_poses.pop_front();
        if (got !== want) begin
          errors = errors + 1;
          if (reported < 10)
            $display("mismatch: expected %h got %h", want, got);
          reported = reported + 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > 600000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic [3:0] idx, logic [63:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    body_config(idx, d);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_events.size() > 0 || expected_poses.size() > 0 || s_tvalid)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_q();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'h7fffffff;
      2: return 32'h80000000;
      default: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
    endcase
  endfunction

  function automatic event_t rand_event();
    event_t e;
    e.func = $urandom_range(0, 99) < 3 ? 4'($urandom_range(10, 15))
           : $urandom_range(0, 99) < 30 ? rbvi_pkg::FN_STEP : 4'($urandom_range(0, 9));
    e.vx = rand_q(); e.vy = rand_q(); e.sc = rand_q(); e.px = rand_q(); e.py = rand_q();
    return e;
  endfunction

  function automatic logic [63:0] rand_limits();
    logic [31:0] lo, hi;
    lo = 32'($signed($urandom_range(0, 1 << 22)) - (1 << 23));
    hi = 32'($signed($urandom_range(0, 1 << 22)));
    return $urandom_range(0, 7) == 0 ? {32'h7fffffff, 32'h80000000}
         : $urandom_range(0, 7) == 0 ? {lo, hi} : {hi, lo};
  endfunction

  initial begin
    event_t e;
    body_reset();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // directed: every func, field extremes, frozen and zero-inverse cases
    write_reg(rbvi_pkg::REG_LIM_X, {32'h7fffffff, 32'h80000000});
    write_reg(rbvi_pkg::REG_LIM_Y, {32'h7fffffff, 32'h80000000});
    write_reg(rbvi_pkg::REG_LIM_ANG, {32'h7fffffff, 32'h80000000});
    write_reg(rbvi_pkg::REG_WEIGHT, {32'hfff6_0000, 32'h0001_0000});
    write_reg(REG_UNKNOWN, 64'hffff_ffff_ffff_ffff);
    for (int f = 0; f < 16; f++) begin
      e.func = 4'(f); e.vx = 32'h7fffffff; e.vy = 32'h80000000; e.sc = 32'h7fffffff;
      e.px = 32'h80000000; e.py = 32'h7fffffff;
      pending_events.push_back(e);
      e.func = rbvi_pkg::FN_STEP; pending_events.push_back(e);
    end
    drain();
    write_reg(rbvi_pkg::REG_INV_MASS, 64'd0);
    write_reg(rbvi_pkg::REG_INV_INERT, 64'd0);
    write_reg(rbvi_pkg::REG_FREEZE, 64'd7);
    for (int f = 0; f < 10; f++) begin
      e = rand_event(); e.func = 4'(f); pending_events.push_back(e);
    end
    drain();
    // random phases over several register settings
    for (int ph = 0; ph < 11; ph++) begin
      write_reg(rbvi_pkg::REG_TIME_STEP, ph == 0 ? 64'h7fffffff : ph == 1 ? 64'd0
                               : 64'($urandom_range(1, 1 << 16)));
      write_reg(rbvi_pkg::REG_INV_MASS,
                ph == 2 ? 64'h7fffffff : 64'($urandom_range(0, 1 << 18)));
      write_reg(rbvi_pkg::REG_INV_INERT,
                ph == 3 ? 64'h7fffffff : 64'($urandom_range(0, 1 << 18)));
      write_reg(rbvi_pkg::REG_WEIGHT, {$urandom, $urandom});
      write_reg(rbvi_pkg::REG_LIM_X, rand_limits());
      write_reg(rbvi_pkg::REG_LIM_Y, rand_limits());
      write_reg(rbvi_pkg::REG_LIM_ANG, rand_limits());
      write_reg(rbvi_pkg::REG_FREEZE, ph < 4 ? 64'd0 : 64'($urandom_range(0, 7)));
      if (ph == 10) quiet = 1;
      for (int i = 0; i < 150; i++) pending_events.push_back(rand_event());
      if (ph == 5) begin
        hold_off = 1;
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      drain();
    end
    $display("covered %0d result beats over 11 random register settings", received);
    $display("all event codes, freeze masks, saturation extremes and a long output stall");
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule

// ----- files.f -----
+incdir+src
src/rbvi_pkg.sv
src/rbvi_mul.sv
src/rigid_body_verlet_integrator.sv
src/rbvi_checker.sv
dv/rigid_body_verlet_integrator_test.sv
